// ===== hw/rtl/dd_odom_pkg.sv =====
`default_nettype none

package dd_odom_pkg;

    // Port and field widths
    localparam int SPEED_W   = 13;
    localparam int DPS_W     = 24;
    localparam int IWB_W     = 16;
    localparam int PPM_W     = 16;
    localparam int CFG_W     = 24;
    localparam int CFG_IDX_W = 2;
    localparam int POS_W     = 32;
    localparam int HEAD_W    = 19;
    localparam int STEP_W    = 16;

    // Datapath widths
    localparam int SUM_W   = 14;  // left +/- right speed
    localparam int MUL_A_W = 38;
    localparam int MUL_B_W = 25;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;
    localparam int FWD_W   = 37;  // forward step, Q.32 metres
    localparam int ANGLE_W = 32;  // biased heading sum, always positive
    localparam int QEST_W  = 14;  // quotient estimate of the heading wrap
    localparam int REM_W   = 20;
    localparam int PX_W    = 37;  // step in Q.16 pixels
    localparam int XY_W    = 40;
    localparam int Z_W     = 28;  // residual angle, Q.24 radians
    localparam int ITER_W  = 5;
    localparam int ATAN_W  = 24;
    localparam int SX_W    = 32;

    // Register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_DIST_PER_SPEED = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INV_WHEEL_BASE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PIX_PER_METER  = 2'd2;

    localparam logic [DPS_W-1:0] DPS_RESET = 24'd33554;
    localparam logic [IWB_W-1:0] IWB_RESET = 16'd5120;
    localparam logic [PPM_W-1:0] PPM_RESET = 16'd5000;

    // Angle constants, Q3.16
    localparam logic signed [HEAD_W-1:0] PI_H      = 19'sd205887;
    localparam logic signed [HEAD_W-1:0] HALF_PI_H = 19'sd102944;
    localparam logic [REM_W-1:0]         TWO_PI_R  = 20'd411775;
    localparam logic signed [REM_W:0]    PI_W      = 21'sd205887;
    localparam logic signed [REM_W:0]    TWO_PI_PI = 21'sd617662;
    // pi plus 4096 turns: keeps the heading sum positive before the wrap
    localparam logic [ANGLE_W-1:0]       ANGLE_BIAS = 32'd1686836287;

    // Multiplier constants
    localparam logic signed [MUL_B_W-1:0] INV_GAIN_B = 25'sd10188014;
    localparam logic signed [MUL_B_W-1:0] RECIP_B    = 25'sd2670175;  // floor(2^40 / 411775), 411775 being 2pi in Q3.16
    localparam logic signed [MUL_B_W-1:0] TWO_PI_B   = 25'sd411775;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL_SUM,
        ST_MUL_DIF,
        ST_MUL_IWB,
        ST_MUL_PPM,
        ST_MUL_RECIP,
        ST_MUL_MOD,
        ST_MUL_GAIN,
        ST_WRAP,
        ST_FOLD,
        ST_ROTATE,
        ST_ROUND,
        ST_COMMIT
    } step_t;

    typedef enum logic [2:0] {
        A_SUM,
        A_DIF,
        A_DIST,
        A_FWD,
        A_UHI,
        A_QEST,
        A_PX
    } a_sel_t;

    typedef enum logic [2:0] {
        B_DPS,
        B_IWB,
        B_PPM,
        B_INVG,
        B_RECIP,
        B_MOD
    } b_sel_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_CAPTURE,
        OP_LOAD_FWD,
        OP_LOAD_ANGLE,
        OP_LOAD_PIX,
        OP_LOAD_REM,
        OP_WRAP,
        OP_FOLD,
        OP_ROTATE,
        OP_ROUND,
        OP_COMMIT
    } op_t;

    typedef enum logic [2:0] {
        JMP_NEXT,
        JMP_IN,
        JMP_LOOP,
        JMP_OUT,
        JMP_GOTO
    } jmp_t;

    typedef struct packed {
        a_sel_t a_sel;
        b_sel_t b_sel;
        logic   mul_en;
        op_t    op;
        jmp_t   jmp;
        step_t  target;
    } ctrl_t;

    typedef struct packed {
        logic in_fire;
        logic iter_last;
        logic out_blocked;
    } status_t;

    localparam ctrl_t CTRL_NOP = '{
        a_sel:  A_SUM,
        b_sel:  B_DPS,
        mul_en: 1'b0,
        op:     OP_NONE,
        jmp:    JMP_NEXT,
        target: ST_IDLE
    };

    // atan(2^-i) in Q.24 radians
    function automatic logic [ATAN_W-1:0] atan_q24(input logic [ITER_W-1:0] i);
        logic [ATAN_W-1:0] v;
        begin
            case (i)
                5'd0:    v = 24'd13176795;
                5'd1:    v = 24'd7778716;
                5'd2:    v = 24'd4110060;
                5'd3:    v = 24'd2086331;
                5'd4:    v = 24'd1047214;
                5'd5:    v = 24'd524117;
                5'd6:    v = 24'd262123;
                5'd7:    v = 24'd131069;
                5'd8:    v = 24'd65536;
                5'd9:    v = 24'd32768;
                5'd10:   v = 24'd16384;
                5'd11:   v = 24'd8192;
                5'd12:   v = 24'd4096;
                5'd13:   v = 24'd2048;
                5'd14:   v = 24'd1024;
                5'd15:   v = 24'd512;
                5'd16:   v = 24'd256;
                5'd17:   v = 24'd128;
                5'd18:   v = 24'd64;
                5'd19:   v = 24'd32;
                5'd20:   v = 24'd16;
                5'd21:   v = 24'd8;
                5'd22:   v = 24'd4;
                5'd23:   v = 24'd2;
                default: v = '0;
            endcase
            return v;
        end
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/dd_odom_seq.sv =====
`default_nettype none

module dd_odom_seq
    import dd_odom_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire status_t status,
    output ctrl_t        ctrl
);

    step_t step_reg;
    step_t step_next;

    // Microcode ROM: one control word per step
    always_comb
    begin
        ctrl = CTRL_NOP;
        unique case (step_reg)
            ST_IDLE:
            begin
                ctrl.op  = OP_CAPTURE;
                ctrl.jmp = JMP_IN;
            end
            ST_MUL_SUM:
            begin
                ctrl.a_sel  = A_SUM;
                ctrl.b_sel  = B_DPS;
                ctrl.mul_en = 1'b1;
            end
            ST_MUL_DIF:
            begin
                ctrl.a_sel  = A_DIF;
                ctrl.b_sel  = B_DPS;
                ctrl.mul_en = 1'b1;
                ctrl.op     = OP_LOAD_FWD;
            end
            ST_MUL_IWB:
            begin
                ctrl.a_sel  = A_DIST;
                ctrl.b_sel  = B_IWB;
                ctrl.mul_en = 1'b1;
            end
            ST_MUL_PPM:
            begin
                ctrl.a_sel  = A_FWD;
                ctrl.b_sel  = B_PPM;
                ctrl.mul_en = 1'b1;
                ctrl.op     = OP_LOAD_ANGLE;
            end
            ST_MUL_RECIP:
            begin
                ctrl.a_sel  = A_UHI;
                ctrl.b_sel  = B_RECIP;
                ctrl.mul_en = 1'b1;
                ctrl.op     = OP_LOAD_PIX;
            end
            ST_MUL_MOD:
            begin
                ctrl.a_sel  = A_QEST;
                ctrl.b_sel  = B_MOD;
                ctrl.mul_en = 1'b1;
            end
            ST_MUL_GAIN:
            begin
                ctrl.a_sel  = A_PX;
                ctrl.b_sel  = B_INVG;
                ctrl.mul_en = 1'b1;
                ctrl.op     = OP_LOAD_REM;
            end
            ST_WRAP:
            begin
                ctrl.op = OP_WRAP;
            end
            ST_FOLD:
            begin
                ctrl.op = OP_FOLD;
            end
            ST_ROTATE:
            begin
                ctrl.op     = OP_ROTATE;
                ctrl.jmp    = JMP_LOOP;
                ctrl.target = ST_ROTATE;
            end
            ST_ROUND:
            begin
                ctrl.op = OP_ROUND;
            end
            ST_COMMIT:
            begin
                ctrl.op     = OP_COMMIT;
                ctrl.jmp    = JMP_OUT;
                ctrl.target = ST_IDLE;
            end
            default:
            begin
                ctrl.jmp    = JMP_GOTO;
                ctrl.target = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        unique case (ctrl.jmp)
            JMP_NEXT: step_next = step_t'(step_reg + 4'd1);
            JMP_IN:   step_next = status.in_fire ? step_t'(step_reg + 4'd1) : step_reg;
            JMP_LOOP: step_next = status.iter_last ? step_t'(step_reg + 4'd1) : ctrl.target;
            JMP_OUT:  step_next = status.out_blocked ? step_reg : ctrl.target;
            JMP_GOTO: step_next = ctrl.target;
            default:  step_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= ST_IDLE;
        end
        else
        begin
            step_reg <= step_next;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/dd_odom_dp.sv =====
`default_nettype none

module dd_odom_dp
    import dd_odom_pkg::*;
#(
    parameter int CORDIC_STEPS = 16
)
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire ctrl_t                     ctrl,
    output status_t                        status,
    input  wire logic [DPS_W-1:0]          dps,
    input  wire logic [IWB_W-1:0]          iwb,
    input  wire logic [PPM_W-1:0]          ppm,
    input  wire logic                      in_valid,
    output logic                           in_stall,
    input  wire logic signed [SPEED_W-1:0] left_speed,
    input  wire logic signed [SPEED_W-1:0] right_speed,
    output logic                           out_valid,
    input  wire logic                      out_stall,
    output logic signed [POS_W-1:0]        new_x,
    output logic signed [POS_W-1:0]        new_y,
    output logic signed [HEAD_W-1:0]       new_heading,
    output logic signed [STEP_W-1:0]       step_x,
    output logic signed [STEP_W-1:0]       step_y
);

    localparam logic [ITER_W-1:0] ITER_LAST = ITER_W'(CORDIC_STEPS - 1);

    // control state
    logic                     out_valid_reg, out_valid_next;
    logic [ITER_W-1:0]        iter_reg, iter_next;
    logic signed [HEAD_W-1:0] head_reg, head_next;
    logic [POS_W-1:0]         pos_x_reg, pos_x_next;
    logic [POS_W-1:0]         pos_y_reg, pos_y_next;

    // payload
    logic signed [SUM_W-1:0]  sum_reg, sum_next;
    logic signed [SUM_W-1:0]  dif_reg, dif_next;
    logic signed [PROD_W-1:0] prod_reg, prod_next;
    logic signed [FWD_W-1:0]  fwd_reg, fwd_next;
    logic [ANGLE_W-1:0]       angle_reg, angle_next;
    logic [REM_W-1:0]         rem_reg, rem_next;
    logic signed [PX_W-1:0]   px_reg, px_next;
    logic signed [XY_W-1:0]   x_reg, x_next;
    logic signed [XY_W-1:0]   y_reg, y_next;
    logic signed [Z_W-1:0]    z_reg, z_next;
    logic signed [SX_W-1:0]   sx_reg, sx_next;
    logic signed [SX_W-1:0]   sy_reg, sy_next;
    logic signed [HEAD_W-1:0] hout_reg, hout_next;
    logic signed [STEP_W-1:0] step_x_reg, step_x_next;
    logic signed [STEP_W-1:0] step_y_reg, step_y_next;

    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic                      in_fire;
    logic                      out_blocked;
    logic [ANGLE_W-1:0]        rem_diff;
    logic signed [REM_W:0]     rem_s;
    logic signed [REM_W:0]     wrap_val;
    logic signed [HEAD_W-1:0]  fold_z;
    logic                      fold_neg;
    logic signed [XY_W-1:0]    px_ext;
    logic signed [XY_W-1:0]    xs;
    logic signed [XY_W-1:0]    ys;
    logic signed [Z_W-1:0]     atan_z;
    logic signed [XY_W-1:0]    x_rnd;
    logic signed [XY_W-1:0]    y_rnd;

    function automatic logic signed [STEP_W-1:0] sat_step(input logic signed [SX_W-1:0] v);
        logic signed [STEP_W-1:0] r;
        begin
            if (v > SX_W'(32767))
                r = 16'sh7FFF;
            else if (v < -SX_W'(32768))
                r = 16'sh8000;
            else
                r = v[STEP_W-1:0];
            return r;
        end
    endfunction

    assign in_stall    = (ctrl.op != OP_CAPTURE);
    assign in_fire     = in_valid && !in_stall;
    assign out_blocked = out_valid_reg && out_stall;

    assign status.in_fire     = in_fire;
    assign status.iter_last   = (iter_reg == ITER_LAST);
    assign status.out_blocked = out_blocked;

    assign out_valid   = out_valid_reg;
    assign new_x       = pos_x_reg;
    assign new_y       = pos_y_reg;
    assign new_heading = hout_reg;
    assign step_x      = step_x_reg;
    assign step_y      = step_y_reg;

    // shared multiplier operands
    always_comb
    begin
        unique case (ctrl.a_sel)
            A_SUM:   mul_a = {{(MUL_A_W-SUM_W){sum_reg[SUM_W-1]}}, sum_reg};
            A_DIF:   mul_a = {{(MUL_A_W-SUM_W){dif_reg[SUM_W-1]}}, dif_reg};
            A_DIST:  mul_a = prod_reg[MUL_A_W-1:0];
            A_FWD:   mul_a = {{(MUL_A_W-FWD_W){fwd_reg[FWD_W-1]}}, fwd_reg};
            A_UHI:   mul_a = {{(MUL_A_W-ANGLE_W+8){1'b0}}, angle_reg[ANGLE_W-1:8]};
            A_QEST:  mul_a = {{(MUL_A_W-QEST_W){1'b0}}, prod_reg[32+QEST_W-1:32]};
            A_PX:    mul_a = {{(MUL_A_W-PX_W){px_reg[PX_W-1]}}, px_reg};
            default: mul_a = '0;
        endcase
        unique case (ctrl.b_sel)
            B_DPS:   mul_b = {1'b0, dps};
            B_IWB:   mul_b = {{(MUL_B_W-IWB_W){1'b0}}, iwb};
            B_PPM:   mul_b = {{(MUL_B_W-PPM_W){1'b0}}, ppm};
            B_INVG:  mul_b = INV_GAIN_B;
            B_RECIP: mul_b = RECIP_B;
            B_MOD:   mul_b = TWO_PI_B;
            default: mul_b = '0;
        endcase
    end

    always_comb
    begin
        rem_diff = angle_reg - prod_reg[ANGLE_W-1:0];
        rem_s    = $signed({1'b0, rem_reg});
        // quotient estimate is low by at most one turn
        wrap_val = (rem_reg >= TWO_PI_R) ? (rem_s - TWO_PI_PI) : (rem_s - PI_W);

        // fold heading into the right half plane, flipping the step
        if (head_reg > HALF_PI_H)
        begin
            fold_z   = head_reg - PI_H;
            fold_neg = 1'b1;
        end
        else if (head_reg < -HALF_PI_H)
        begin
            fold_z   = head_reg + PI_H;
            fold_neg = 1'b1;
        end
        else
        begin
            fold_z   = head_reg;
            fold_neg = 1'b0;
        end
        px_ext = {{(XY_W-PX_W){px_reg[PX_W-1]}}, px_reg};

        xs     = x_reg >>> iter_reg;
        ys     = y_reg >>> iter_reg;
        atan_z = $signed({{(Z_W-ATAN_W){1'b0}}, atan_q24(iter_reg)});
        x_rnd  = x_reg + XY_W'(128);
        y_rnd  = y_reg + XY_W'(128);
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        iter_next      = iter_reg;
        head_next      = head_reg;
        pos_x_next     = pos_x_reg;
        pos_y_next     = pos_y_reg;
        sum_next       = sum_reg;
        dif_next       = dif_reg;
        prod_next      = prod_reg;
        fwd_next       = fwd_reg;
        angle_next     = angle_reg;
        rem_next       = rem_reg;
        px_next        = px_reg;
        x_next         = x_reg;
        y_next         = y_reg;
        z_next         = z_reg;
        sx_next        = sx_reg;
        sy_next        = sy_reg;
        hout_next      = hout_reg;
        step_x_next    = step_x_reg;
        step_y_next    = step_y_reg;

        if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;

        if (ctrl.mul_en)
            prod_next = mul_a * mul_b;

        unique case (ctrl.op)
            OP_NONE:
            begin
            end
            OP_CAPTURE:
            begin
                if (in_fire)
                begin
                    sum_next = {left_speed[SPEED_W-1], left_speed}
                             + {right_speed[SPEED_W-1], right_speed};
                    dif_next = {left_speed[SPEED_W-1], left_speed}
                             - {right_speed[SPEED_W-1], right_speed};
                end
            end
            OP_LOAD_FWD:
            begin
                fwd_next = prod_reg[FWD_W:1];
            end
            OP_LOAD_ANGLE:
            begin
                // heading delta rounded half up: bits 53..24 plus bit 23
                angle_next = {{(ANGLE_W-HEAD_W){head_reg[HEAD_W-1]}}, head_reg}
                           + {{2{prod_reg[53]}}, prod_reg[53:24]}
                           + {{(ANGLE_W-1){1'b0}}, prod_reg[23]}
                           + ANGLE_BIAS;
            end
            OP_LOAD_PIX:
            begin
                px_next = prod_reg[PX_W+15:16];
            end
            OP_LOAD_REM:
            begin
                rem_next = rem_diff[REM_W-1:0];
            end
            OP_WRAP:
            begin
                px_next   = prod_reg[PX_W+23:24];
                head_next = wrap_val[HEAD_W-1:0];
            end
            OP_FOLD:
            begin
                z_next    = {{(Z_W-8-HEAD_W){fold_z[HEAD_W-1]}}, fold_z, 8'b0};
                x_next    = fold_neg ? -px_ext : px_ext;
                y_next    = '0;
                iter_next = '0;
            end
            OP_ROTATE:
            begin
                if (!z_reg[Z_W-1])
                begin
                    x_next = x_reg - ys;
                    y_next = y_reg + xs;
                    z_next = z_reg - atan_z;
                end
                else
                begin
                    x_next = x_reg + ys;
                    y_next = y_reg - xs;
                    z_next = z_reg + atan_z;
                end
                iter_next = iter_reg + ITER_W'(1);
            end
            OP_ROUND:
            begin
                sx_next = x_rnd[XY_W-1:8];
                sy_next = y_rnd[XY_W-1:8];
            end
            OP_COMMIT:
            begin
                if (!out_blocked)
                begin
                    pos_x_next     = pos_x_reg + sx_reg;
                    pos_y_next     = pos_y_reg + sy_reg;
                    hout_next      = head_reg;
                    step_x_next    = sat_step(sx_reg);
                    step_y_next    = sat_step(sy_reg);
                    out_valid_next = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            iter_reg      <= '0;
            head_reg      <= '0;
            pos_x_reg     <= '0;
            pos_y_reg     <= '0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            iter_reg      <= iter_next;
            head_reg      <= head_next;
            pos_x_reg     <= pos_x_next;
            pos_y_reg     <= pos_y_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sum_reg    <= sum_next;
        dif_reg    <= dif_next;
        prod_reg   <= prod_next;
        fwd_reg    <= fwd_next;
        angle_reg  <= angle_next;
        rem_reg    <= rem_next;
        px_reg     <= px_next;
        x_reg      <= x_next;
        y_reg      <= y_next;
        z_reg      <= z_next;
        sx_reg     <= sx_next;
        sy_reg     <= sy_next;
        hout_reg   <= hout_next;
        step_x_reg <= step_x_next;
        step_y_reg <= step_y_next;
    end

endmodule

`default_nettype wire

// ===== hw/rtl/differential_drive_odometry_core.sv =====
// Channel   Handshake                Payload
// input     in_valid / in_stall      left_speed, right_speed
// output    out_valid / out_stall    new_x, new_y, new_heading, step_x, step_y
// config    cfg_we                   cfg_index, cfg_data
//
// A transaction is accepted only in the idle step; it then runs the microcode sequence
// of seven steps through the one shared 38x25 multiplier, then heading wrap and fold,
// one CORDIC rotation per cycle, rounding and commit.
// Reset clears position, heading and the config registers to their defaults.
// A result waits in the output register; a new transaction is accepted meanwhile,
// and the sequencer holds in its commit step only while out_stall keeps it full.
`default_nettype none

module differential_drive_odometry_core
    import dd_odom_pkg::*;
#(
    parameter int CORDIC_STEPS = 16
)
(
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        cfg_we,
    input  wire logic [CFG_IDX_W-1:0]        cfg_index,
    input  wire logic [CFG_W-1:0]            cfg_data,
    input  wire logic                        in_valid,
    output logic                             in_stall,
    input  wire logic signed [SPEED_W-1:0]   left_speed,
    input  wire logic signed [SPEED_W-1:0]   right_speed,
    output logic                             out_valid,
    input  wire logic                        out_stall,
    output logic signed [POS_W-1:0]         new_x,
    output logic signed [POS_W-1:0]         new_y,
    output logic signed [HEAD_W-1:0]        new_heading,
    output logic signed [STEP_W-1:0]        step_x,
    output logic signed [STEP_W-1:0]        step_y
);

    logic [DPS_W-1:0] dps_reg, dps_next;
    logic [IWB_W-1:0] iwb_reg, iwb_next;
    logic [PPM_W-1:0] ppm_reg, ppm_next;

    ctrl_t   ctrl;
    status_t status;

    always_comb
    begin
        dps_next = dps_reg;
        iwb_next = iwb_reg;
        ppm_next = ppm_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_DIST_PER_SPEED: dps_next = cfg_data[DPS_W-1:0];
                CFG_INV_WHEEL_BASE: iwb_next = cfg_data[IWB_W-1:0];
                CFG_PIX_PER_METER:  ppm_next = cfg_data[PPM_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dps_reg <= DPS_RESET;
            iwb_reg <= IWB_RESET;
            ppm_reg <= PPM_RESET;
        end
        else
        begin
            dps_reg <= dps_next;
            iwb_reg <= iwb_next;
            ppm_reg <= ppm_next;
        end
    end

    dd_odom_seq u_seq (
        .clk    (clk),
        .rst_n  (rst_n),
        .status (status),
        .ctrl   (ctrl)
    );

    dd_odom_dp #(
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctrl        (ctrl),
        .status      (status),
        .dps         (dps_reg),
        .iwb         (iwb_reg),
        .ppm         (ppm_reg),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .left_speed  (left_speed),
        .right_speed (right_speed),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .new_x       (new_x),
        .new_y       (new_y),
        .new_heading (new_heading),
        .step_x      (step_x),
        .step_y      (step_y)
    );

    // an accepted transaction keeps the input side busy on the next cycle
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("input accepted twice in a row");

    a_heading_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (new_heading >= -PI_H) && (new_heading <= PI_H))
        else $error("reported heading outside -pi..pi");

    // position only moves when a new result is loaded
    a_pos_moves_with_result: assert property (@(posedge clk) disable iff (!rst_n)
        (!$stable(new_x) || !$stable(new_y)) |-> out_valid)
        else $error("position changed without a result");

endmodule

`default_nettype wire
